// ===== design/rfdm_pkg.sv =====
// ----------------------------------------------------------------------------
// rfdm_pkg
// Shared types and constants of the RGB frame difference marker.
// ----------------------------------------------------------------------------
`default_nettype none

package rfdm_pkg;

  // Output mode codes (unchanged pixel / changed pixel)
  localparam logic [2:0] MODE_FILL_MARK = 3'd1;
  localparam logic [2:0] MODE_REF_MARK  = 3'd2;
  localparam logic [2:0] MODE_REF_BLEND = 3'd3;
  localparam logic [2:0] MODE_FILL_CUR  = 3'd4;

  // Blend divisor is 100 / transparency percent
  localparam int PERCENT_FULL = 100;

  // Fixed-point shift of the blend reciprocal; exact for sums below 512
  localparam int RECIP_SHIFT = 20;

  // Per-stage load strobes shared by all colour lanes
  typedef struct packed {
    logic load1;
    logic load2;
    logic load3;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

// ===== design/rfdm_lane.sv =====
// ----------------------------------------------------------------------------
// rfdm_lane
// One colour channel of the marker pipeline: difference, threshold test,
// blend by reciprocal multiply and final output selection.
// ----------------------------------------------------------------------------
`default_nettype none

module rfdm_lane import rfdm_pkg::*; #(
  parameter int TRANSPARENCY_PERCENT = 50
) (
  input  wire logic       clk,
  input  wire pipe_ctrl_t ctrl,
  input  wire logic [7:0] threshold,
  input  wire logic [7:0] mark,
  input  wire logic [7:0] fill_level,
  input  wire logic [2:0] output_mode,
  input  wire logic [7:0] ref_pix,
  input  wire logic [7:0] cur_pix,
  input  wire logic       changed,
  output logic            over,
  output logic      [7:0] out_pix
);

  localparam int BLEND_DIV  = PERCENT_FULL / TRANSPARENCY_PERCENT;
  localparam int BLEND_MULT = ((1 << RECIP_SHIFT) + BLEND_DIV - 1) / BLEND_DIV;
  localparam int MULT_W     = RECIP_SHIFT + 1;
  localparam int SUM_W      = 9;
  localparam int PROD_W     = SUM_W + MULT_W;
  localparam int QUOT_W     = PROD_W - RECIP_SHIFT;

  // Stage 1 registers
  logic [7:0]        diff1;
  logic [7:0]        ref1;
  logic [7:0]        cur1;
  logic [SUM_W-1:0]  sum1;
  logic              zero1;

  // Stage 2 registers
  logic [7:0]        ref2;
  logic [7:0]        cur2;
  logic [PROD_W-1:0] prod2;
  logic              zero2;

  logic [7:0]        diff_next;
  logic [QUOT_W-1:0] quot;
  logic [7:0]        blend;
  logic [7:0]        out_pix_next;

  // Absolute difference of the two pixels
  assign diff_next = (cur_pix >= ref_pix) ? (cur_pix - ref_pix) : (ref_pix - cur_pix);

  // Stage 1: difference, blend sum and zero test
  always_ff @(posedge clk) begin
    if (ctrl.load1) begin
      diff1 <= diff_next;
      ref1  <= ref_pix;
      cur1  <= cur_pix;
      sum1  <= {1'b0, mark} + {1'b0, ref_pix};
      zero1 <= (mark == 8'd0) || (ref_pix == 8'd0);
    end
  end

  // Stage 2: threshold compare and reciprocal multiply
  always_ff @(posedge clk) begin
    if (ctrl.load2) begin
      over  <= diff1 > threshold;
      ref2  <= ref1;
      cur2  <= cur1;
      prod2 <= PROD_W'(sum1) * PROD_W'(MULT_W'(BLEND_MULT));
      zero2 <= zero1;
    end
  end

  // Quotient of the blend, saturated to eight bits
  assign quot  = prod2[RECIP_SHIFT +: QUOT_W];
  assign blend = zero2 ? 8'd0 : ((quot > QUOT_W'(255)) ? 8'd255 : quot[7:0]);

  // Pick the result for this channel
  always_comb begin
    case (output_mode)
      MODE_FILL_MARK: out_pix_next = changed ? mark  : fill_level;
      MODE_REF_MARK:  out_pix_next = changed ? mark  : ref2;
      MODE_REF_BLEND: out_pix_next = changed ? blend : ref2;
      MODE_FILL_CUR:  out_pix_next = changed ? cur2  : fill_level;
      default:        out_pix_next = 8'd0;
    endcase
  end

  // Stage 3: output register
  always_ff @(posedge clk) begin
    if (ctrl.load3) begin
      out_pix <= out_pix_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/rgb_frame_difference_marker_top.sv =====
// ----------------------------------------------------------------------------
// rgb_frame_difference_marker_top
// Marks pixels that differ between a reference and a current frame.
//
// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------
// pixel in | pix_valid / pix_ready | ref_*, cur_* (8b each), frame_end
// result   | res_valid / res_ready | out_red/green/blue (8b), frame_end_out
// config   | APB, pready tied high | paddr[4:0], pwdata / prdata (32b)
//
// One pixel per clock while res_ready does not stall, through three register
// stages (difference, compare and multiply, select); res_valid rises when the
// pixel reaches the output register, where the result can then be taken.
// Each stage takes a new pixel when it is empty or its successor moves on,
// so a stall on res_ready backs up through the stages without loss.
// Synchronous reset empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_frame_difference_marker_top import rfdm_pkg::*; #(
  parameter int TRANSPARENCY_PERCENT = 50
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Pixel input
  input  wire logic        pix_valid,
  output logic             pix_ready,
  input  wire logic [7:0]  ref_red,
  input  wire logic [7:0]  ref_green,
  input  wire logic [7:0]  ref_blue,
  input  wire logic [7:0]  cur_red,
  input  wire logic [7:0]  cur_green,
  input  wire logic [7:0]  cur_blue,
  input  wire logic        frame_end,
  // Result output
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic      [7:0]  out_red,
  output logic      [7:0]  out_green,
  output logic      [7:0]  out_blue,
  output logic             frame_end_out
);

  localparam logic [2:0] REG_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_MARK_RED   = 3'd1;
  localparam logic [2:0] REG_MARK_GREEN = 3'd2;
  localparam logic [2:0] REG_MARK_BLUE  = 3'd3;
  localparam logic [2:0] REG_MODE       = 3'd4;
  localparam logic [2:0] REG_FILL       = 3'd5;

  logic [7:0] threshold;
  logic [7:0] mark_red;
  logic [7:0] mark_green;
  logic [7:0] mark_blue;
  logic [2:0] output_mode;
  logic [7:0] fill_level;

  logic       cfg_write;
  logic [2:0] cfg_index;

  logic       valid1;
  logic       valid2;
  logic       frame_end1;
  logic       frame_end2;
  logic       ready1;
  logic       ready2;
  logic       ready3;
  pipe_ctrl_t ctrl;

  logic       over_red;
  logic       over_green;
  logic       over_blue;
  logic       changed;

  // Configuration write strobe and register index
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= 8'd0;
      mark_red    <= 8'd255;
      mark_green  <= 8'd0;
      mark_blue   <= 8'd0;
      output_mode <= MODE_FILL_MARK;
      fill_level  <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD:  threshold   <= pwdata[7:0];
        REG_MARK_RED:   mark_red    <= pwdata[7:0];
        REG_MARK_GREEN: mark_green  <= pwdata[7:0];
        REG_MARK_BLUE:  mark_blue   <= pwdata[7:0];
        REG_MODE:       output_mode <= pwdata[2:0];
        REG_FILL:       fill_level  <= pwdata[7:0];
        default:        ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (cfg_index)
      REG_THRESHOLD:  prdata = {24'd0, threshold};
      REG_MARK_RED:   prdata = {24'd0, mark_red};
      REG_MARK_GREEN: prdata = {24'd0, mark_green};
      REG_MARK_BLUE:  prdata = {24'd0, mark_blue};
      REG_MODE:       prdata = {29'd0, output_mode};
      REG_FILL:       prdata = {24'd0, fill_level};
      default:        prdata = 32'd0;
    endcase
  end

  // Stage readiness: a stage takes data when empty or when it drains
  assign ready3    = !res_valid || res_ready;
  assign ready2    = !valid2 || ready3;
  assign ready1    = !valid1 || ready2;
  assign pix_ready = ready1;

  assign ctrl.load1 = pix_valid && ready1;
  assign ctrl.load2 = valid1 && ready2;
  assign ctrl.load3 = valid2 && ready3;

  // Advance valid bits along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (ready1) begin
        valid1 <= pix_valid;
      end
      if (ready2) begin
        valid2 <= valid1;
      end
      if (ready3) begin
        res_valid <= valid2;
      end
    end
  end

  // Carry the frame marker alongside the pixel
  always_ff @(posedge clk) begin
    if (ctrl.load1) begin
      frame_end1 <= frame_end;
    end
    if (ctrl.load2) begin
      frame_end2 <= frame_end1;
    end
    if (ctrl.load3) begin
      frame_end_out <= frame_end2;
    end
  end

  // A pixel has changed if any channel exceeds the threshold
  assign changed = over_red || over_green || over_blue;

  rfdm_lane #(
    .TRANSPARENCY_PERCENT(TRANSPARENCY_PERCENT)
  ) u_lane_red (
    .clk        (clk),
    .ctrl       (ctrl),
    .threshold  (threshold),
    .mark       (mark_red),
    .fill_level (fill_level),
    .output_mode(output_mode),
    .ref_pix    (ref_red),
    .cur_pix    (cur_red),
    .changed    (changed),
    .over       (over_red),
    .out_pix    (out_red)
  );

  rfdm_lane #(
    .TRANSPARENCY_PERCENT(TRANSPARENCY_PERCENT)
  ) u_lane_green (
    .clk        (clk),
    .ctrl       (ctrl),
    .threshold  (threshold),
    .mark       (mark_green),
    .fill_level (fill_level),
    .output_mode(output_mode),
    .ref_pix    (ref_green),
    .cur_pix    (cur_green),
    .changed    (changed),
    .over       (over_green),
    .out_pix    (out_green)
  );

  rfdm_lane #(
    .TRANSPARENCY_PERCENT(TRANSPARENCY_PERCENT)
  ) u_lane_blue (
    .clk        (clk),
    .ctrl       (ctrl),
    .threshold  (threshold),
    .mark       (mark_blue),
    .fill_level (fill_level),
    .output_mode(output_mode),
    .ref_pix    (ref_blue),
    .cur_pix    (cur_blue),
    .changed    (changed),
    .over       (over_blue),
    .out_pix    (out_blue)
  );

  // Back-pressure only when every stage is full and the sink stalls
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> (valid1 && valid2 && res_valid && !res_ready))
    else $error("pixel input stalled with a free stage");

  // An accepted transaction always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_ready) |=> valid1)
    else $error("accepted transaction lost at stage 1");

  // Mode 1 gives only the fill grey or the mark colour
  a_mode_fill_mark: assert property (@(posedge clk) disable iff (rst)
    (res_valid && output_mode == MODE_FILL_MARK && $stable(output_mode))
      |-> (out_red == mark_red || out_red == fill_level))
    else $error("fill/mark mode produced another value");

  // Undefined modes give a black pixel
  a_bad_mode_black: assert property (@(posedge clk) disable iff (rst)
    (res_valid && $stable(output_mode) && (output_mode == 3'd0 || output_mode > MODE_FILL_CUR))
      |-> (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
    else $error("undefined mode produced a non-black pixel");

endmodule

`default_nettype wire
